@@ sv/vn_pkg.sv @@
// shared constants for the vector normalizer pipeline
// no dependencies
package vn_pkg;

  localparam int COMP_W     = 32;  // raw component width
  localparam int SQ_W       = 63;  // square of a magnitude, at most 2^62
  localparam int SUM_W      = 64;  // sum of three squares
  localparam int DIV_STEPS  = 61;  // quotient bits of sq*2^60/sum
  localparam int QUO_W      = 61;
  localparam int SQRT_STEPS = 31;  // root bits, root at most 2^30
  localparam int ROOT_W     = 31;
  localparam int LANE_DEPTH = DIV_STEPS + SQRT_STEPS;
  localparam int PRE_DEPTH  = 3;   // magnitude, square, sum

endpackage

@@ sv/vector3_normalizer_top.sv @@
// pipeline from input beat to output beat: 3 front stages,
// 61 divide stages, 31 square root stages, 1 output register
// throughput: one vector per cycle; a stall on the output holds the whole pipe
// reset: rst synchronous, clears all stage valid bits and the output valid
// top level of the vector normalizer; uses vn_pkg and vn_lane
module vector3_normalizer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // x_in [31:0], y_in [63:32], z_in [95:64]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // x_unit [31:0], y_unit [63:32], z_unit [95:64]
  output logic        m_tuser    // zero_vector
);
  import vn_pkg::*;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic [PRE_DEPTH+LANE_DEPTH-1:0] vld;

  logic [COMP_W-1:0] mag [3];
  logic [2:0]        neg_a, neg_b, neg_c;
  logic [SQ_W-1:0]   sq_b [3];
  logic [SQ_W-1:0]   sq_c [3];
  logic [SUM_W-1:0]  sum_c;
  logic [3:0]        meta [LANE_DEPTH];  // {zero, neg}
  logic [ROOT_W-1:0] root [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld      <= {vld[PRE_DEPTH+LANE_DEPTH-2:0], s_tvalid};
      m_tvalid <= vld[PRE_DEPTH+LANE_DEPTH-1];
    end
  end

  genvar i;
  generate
    for (i = 0; i < 3; i++) begin : g_comp
      logic [COMP_W-1:0] c;
      assign c = s_tdata[i*COMP_W +: COMP_W];
      always_ff @(posedge clk) begin
        if (en) begin
          neg_a[i] <= c[COMP_W-1];
          mag[i]   <= c[COMP_W-1] ? COMP_W'(-c) : c;
          sq_b[i]  <= SQ_W'({32'd0, mag[i]} * {32'd0, mag[i]});
          sq_c[i]  <= sq_b[i];
        end
      end
      vn_lane u_lane (
        .clk  (clk),
        .en   (en),
        .sq   (sq_c[i]),
        .sum  (sum_c),
        .root (root[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      neg_b <= neg_a;
      neg_c <= neg_b;
      sum_c <= SUM_W'({1'b0, sq_b[0]}) + SUM_W'({1'b0, sq_b[1]}) + SUM_W'({1'b0, sq_b[2]});
      meta[0] <= {sum_c == '0, neg_c};
      for (int k = 1; k < LANE_DEPTH; k++) meta[k] <= meta[k-1];
    end
  end

  logic [3:0] meta_o;
  assign meta_o = meta[LANE_DEPTH-1];

  generate
    for (i = 0; i < 3; i++) begin : g_out
      logic [COMP_W-1:0] q;
      assign q = {1'b0, root[i]};
      always_ff @(posedge clk) begin
        if (en) begin
          m_tdata[i*COMP_W +: COMP_W] <= meta_o[3] ? '0 : (meta_o[i] ? COMP_W'(-q) : q);
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) m_tuser <= meta_o[3];
  end

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("zero vector beat carries nonzero components");

  a_nonzero_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata != '0)
    else $error("nonzero vector produced an all-zero unit vector");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid && vld == '0)
    else $error("pipeline holds valid beats after reset");

  a_range_x: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[31:0]) <= 32'sd1073741824) &&
                 ($signed(m_tdata[31:0]) >= -32'sd1073741824))
    else $error("x_unit out of range");

endmodule

@@ sv/vn_lane.sv @@
// one component lane: restoring divide of sq*2^60 by the sum, one quotient bit
// per stage, then a restoring square root, one root bit per stage; uses vn_pkg
module vn_lane (
  input  logic                       clk,
  input  logic                       en,
  input  logic [vn_pkg::SQ_W-1:0]    sq,
  input  logic [vn_pkg::SUM_W-1:0]   sum,
  output logic [vn_pkg::ROOT_W-1:0]  root
);
  import vn_pkg::*;

  logic [SUM_W-1:0] drem [DIV_STEPS];
  logic [SUM_W-1:0] dsum [DIV_STEPS];
  logic [QUO_W-1:0] dquo [DIV_STEPS];

  logic [32:0]       srem  [SQRT_STEPS];
  logic [ROOT_W-1:0] sroot [SQRT_STEPS];
  logic [61:0]       sdat  [SQRT_STEPS];

  genvar k;
  generate
    for (k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [SUM_W-1:0] r_in;
      logic [SUM_W-1:0] s_in;
      logic [QUO_W-1:0] q_in;
      logic             b_in;
      logic [SUM_W:0]   t;
      logic             ge;
      if (k == 0) begin : g_first
        // remainder starts at sq*2^60 >> 61, bit 60 of the dividend is sq[0]
        assign r_in = {{(SUM_W-SQ_W+1){1'b0}}, sq[SQ_W-1:1]};
        assign s_in = sum;
        assign q_in = '0;
        assign b_in = sq[0];
      end else begin : g_rest
        assign r_in = drem[k-1];
        assign s_in = dsum[k-1];
        assign q_in = dquo[k-1];
        assign b_in = 1'b0;
      end
      assign t  = {r_in, b_in};
      assign ge = t >= {1'b0, s_in};
      always_ff @(posedge clk) begin
        if (en) begin
          drem[k] <= ge ? SUM_W'(t - {1'b0, s_in}) : t[SUM_W-1:0];
          dsum[k] <= s_in;
          dquo[k] <= {q_in[QUO_W-2:0], ge};
        end
      end
    end

    for (k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      logic [32:0]       r_in;
      logic [ROOT_W-1:0] q_in;
      logic [61:0]       d_in;
      logic [34:0]       t;
      logic [34:0]       trial;
      logic              ge;
      if (k == 0) begin : g_first
        assign r_in = '0;
        assign q_in = '0;
        assign d_in = {1'b0, dquo[DIV_STEPS-1]};
      end else begin : g_rest
        assign r_in = srem[k-1];
        assign q_in = sroot[k-1];
        assign d_in = sdat[k-1];
      end
      assign t     = {r_in, d_in[61:60]};
      assign trial = {2'b00, q_in, 2'b01};
      assign ge    = t >= trial;
      always_ff @(posedge clk) begin
        if (en) begin
          srem[k]  <= ge ? 33'(t - trial) : t[32:0];
          sroot[k] <= {q_in[ROOT_W-2:0], ge};
          sdat[k]  <= {d_in[59:0], 2'b00};
        end
      end
    end
  endgenerate

  assign root = sroot[SQRT_STEPS-1];

endmodule
